>>> rtl/core/pgc_pkg.sv
// Shared types, constants and arithmetic step functions of the particle-gamma cosine block.
// No dependencies; every other file of the block refers to this package by scoped names.
package pgc_pkg;

  typedef enum logic [1:0] {
    MODE_COMPUTE     = 2'd0,
    MODE_LOAD_RING   = 2'd1,
    MODE_LOAD_SECTOR = 2'd2,
    MODE_LOAD_GAMMA  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    REG_BEAM_X      = 2'd0,
    REG_BEAM_Y      = 2'd1,
    REG_BEAM_Z      = 2'd2,
    REG_TARGET_DIST = 2'd3
  } reg_e;

  localparam int unsigned GIDX_W     = 8;
  localparam int unsigned QDEPTH     = 4;
  localparam int unsigned QPTR_W     = 2;
  localparam int unsigned QCNT_W     = 3;
  localparam int unsigned DELTA_W    = 26;
  localparam int unsigned SQ_W       = 49;
  localparam int unsigned SUM_W      = 50;
  localparam int unsigned PROD_W     = 42;
  localparam int unsigned DOT_W      = 44;
  localparam int unsigned MAG_W      = 43;
  localparam int unsigned RAD_W      = 64;
  localparam int unsigned ROOT_W     = 32;
  localparam int unsigned SREM_W     = 35;
  localparam int unsigned SQ_STAGES  = 16;
  localparam int unsigned NUM_W      = 49;
  localparam int unsigned QUO_W      = 16;
  localparam int unsigned DREM_W     = 33;
  localparam int unsigned DIV_STAGES = 8;
  localparam logic [22:0] TD_RESET   = 23'd2202;

  typedef struct packed {
    mode_e              mode;
    logic               ring_ok;
    logic               sec_ok;
    logic               gam_ok;
    logic [4:0]         ring;
    logic [4:0]         sector;
    logic [GIDX_W-1:0]  gidx;
    logic signed [23:0] tx;
    logic signed [15:0] ty;
    logic signed [15:0] tz;
  } item_t;

  typedef struct packed {
    logic signed [23:0] beam_x;
    logic signed [23:0] beam_y;
    logic signed [23:0] beam_z;
    logic [22:0]        target_dist;
  } cfg_t;

  typedef struct packed {
    logic             zero;
    logic             neg;
    logic [MAG_W-1:0] mag;
  } side_t;

  typedef struct packed {
    logic [SREM_W-1:0] rem;
    logic [ROOT_W-1:0] root;
  } sqrt_acc_t;

  typedef struct packed {
    logic [DREM_W-1:0] rem;
    logic [QUO_W-1:0]  quo;
  } div_acc_t;

  // One digit of the bit-pair square root recurrence.
  function automatic sqrt_acc_t sqrt_step(sqrt_acc_t a, logic [1:0] pair);
    logic [SREM_W-1:0] r;
    logic [SREM_W-1:0] t;
    sqrt_acc_t         o;
    r = {a.rem[SREM_W-3:0], pair};
    t = {1'b0, a.root, 2'b01};
    if (r >= t) begin
      o.rem  = r - t;
      o.root = {a.root[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem  = r;
      o.root = {a.root[ROOT_W-2:0], 1'b0};
    end
    return o;
  endfunction

  // One bit of restoring division.
  function automatic div_acc_t div_step(div_acc_t a, logic nb, logic [ROOT_W-1:0] d);
    logic [DREM_W-1:0] r;
    div_acc_t          o;
    r = {a.rem[DREM_W-2:0], nb};
    if (r >= {1'b0, d}) begin
      o.rem = r - {1'b0, d};
      o.quo = {a.quo[QUO_W-2:0], 1'b1};
    end else begin
      o.rem = r;
      o.quo = {a.quo[QUO_W-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

>>> rtl/core/pgc_cfg.sv
// Configuration register bank behind the APB-style port: beam spot and target distance.
// Depends on pgc_pkg for the register codes and the configuration struct.
module pgc_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output pgc_pkg::cfg_t       cfg_o
);

  pgc_pkg::cfg_t cfg_q, cfg_d;
  pgc_pkg::reg_e sel;
  logic          wr_en;

  assign sel    = pgc_pkg::reg_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (sel)
        pgc_pkg::REG_BEAM_X:      cfg_d.beam_x      = pwdata[23:0];
        pgc_pkg::REG_BEAM_Y:      cfg_d.beam_y      = pwdata[23:0];
        pgc_pkg::REG_BEAM_Z:      cfg_d.beam_z      = pwdata[23:0];
        pgc_pkg::REG_TARGET_DIST: cfg_d.target_dist = pwdata[22:0];
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      pgc_pkg::REG_BEAM_X:      prdata = 32'(cfg_q.beam_x);
      pgc_pkg::REG_BEAM_Y:      prdata = 32'(cfg_q.beam_y);
      pgc_pkg::REG_BEAM_Z:      prdata = 32'(cfg_q.beam_z);
      pgc_pkg::REG_TARGET_DIST: prdata = {9'd0, cfg_q.target_dist};
      default:                  prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.beam_x      <= '0;
      cfg_q.beam_y      <= '0;
      cfg_q.beam_z      <= '0;
      cfg_q.target_dist <= pgc_pkg::TD_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

>>> rtl/core/pgc_front.sv
// Front end: accepts command transactions, checks the store indices and queues the items.
// Depends on pgc_pkg for the item struct and the queue dimensions.
module pgc_front #(
  parameter int RINGS       = 32,
  parameter int SECTORS     = 32,
  parameter int GE_MODULES  = 8,
  parameter int GE_CHANNELS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          mode_i,
  input  logic [2:0]          ge_module_i,
  input  logic [3:0]          ge_channel_i,
  input  logic [4:0]          si_ring_i,
  input  logic [4:0]          si_sector_i,
  input  logic signed [23:0]  table_x_i,
  input  logic signed [15:0]  table_y_i,
  input  logic signed [15:0]  table_z_i,
  output logic                item_vld_o,
  output pgc_pkg::item_t      item_o
);

  pgc_pkg::item_t                 queue_q [pgc_pkg::QDEPTH];
  pgc_pkg::item_t                 item_in;
  logic [pgc_pkg::QPTR_W-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [pgc_pkg::QCNT_W-1:0]     count_q, count_d;
  logic                           push, pop;

  always_comb begin
    item_in.mode    = pgc_pkg::mode_e'(mode_i);
    item_in.ring_ok = 32'(si_ring_i) < RINGS;
    item_in.sec_ok  = 32'(si_sector_i) < SECTORS;
    item_in.gam_ok  = (32'(ge_module_i) < GE_MODULES) && (32'(ge_channel_i) < GE_CHANNELS);
    item_in.ring    = si_ring_i;
    item_in.sector  = si_sector_i;
    item_in.gidx    = pgc_pkg::GIDX_W'(32'(ge_module_i) * GE_CHANNELS + 32'(ge_channel_i));
    item_in.tx      = table_x_i;
    item_in.ty      = table_y_i;
    item_in.tz      = table_z_i;
  end

  // The back end takes one item every cycle, so the queue drains as soon as it holds one.
  assign busy       = (count_q == pgc_pkg::QCNT_W'(pgc_pkg::QDEPTH));
  assign push       = start && !busy;
  assign pop        = (count_q != '0);
  assign item_vld_o = pop;
  assign item_o     = queue_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q + pgc_pkg::QPTR_W'(push);
    rd_ptr_d = rd_ptr_q + pgc_pkg::QPTR_W'(pop);
    count_d  = count_q + pgc_pkg::QCNT_W'(push) - pgc_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= item_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

>>> rtl/core/pgc_sqrt.sv
// Pipelined integer square root, two result bits per stage, with a side payload alongside.
// Depends on pgc_pkg for the step function and the payload struct.
module pgc_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        vld_i,
  input  logic [pgc_pkg::RAD_W-1:0]   rad_i,
  input  pgc_pkg::side_t              side_i,
  output logic                        vld_o,
  output logic [pgc_pkg::ROOT_W-1:0]  root_o,
  output pgc_pkg::side_t              side_o
);

  localparam int unsigned N = pgc_pkg::SQ_STAGES;

  logic [N:0]                   vld;
  logic [pgc_pkg::RAD_W-1:0]    rad  [N+1];
  pgc_pkg::sqrt_acc_t           acc  [N+1];
  pgc_pkg::side_t               side [N+1];

  assign vld[0]  = vld_i;
  assign rad[0]  = rad_i;
  assign acc[0]  = '0;
  assign side[0] = side_i;

  for (genvar g = 0; g < N; g++) begin : g_stage
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[g+1] <= 1'b0;
      end else begin
        vld[g+1] <= vld[g];
      end
    end

    always_ff @(posedge clk_i) begin
      acc[g+1]  <= pgc_pkg::sqrt_step(pgc_pkg::sqrt_step(acc[g],
                     rad[g][pgc_pkg::RAD_W-1 -: 2]), rad[g][pgc_pkg::RAD_W-3 -: 2]);
      rad[g+1]  <= rad[g] << 4;
      side[g+1] <= side[g];
    end
  end

  assign vld_o  = vld[N];
  assign root_o = acc[N].root;
  assign side_o = side[N];

endmodule

>>> rtl/core/pgc_div.sv
// Pipelined restoring divider of the scaled dot product by the root, with Q1.15 saturation.
// Depends on pgc_pkg for the step function and the payload struct.
module pgc_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        vld_i,
  input  logic [pgc_pkg::ROOT_W-1:0]  root_i,
  input  pgc_pkg::side_t              side_i,
  output logic                        done_o,
  output logic signed [15:0]          cos_o,
  output logic                        zero_o
);

  localparam int unsigned N  = pgc_pkg::DIV_STAGES;
  localparam int unsigned LO = pgc_pkg::QUO_W;

  typedef struct packed {
    logic                        zero;
    logic                        neg;
    logic                        ovf;
    logic [pgc_pkg::ROOT_W-1:0]  root;
    logic [LO-1:0]               low;
  } dctl_t;

  logic [pgc_pkg::NUM_W-1:0]  num;
  logic [N:0]                 vld;
  pgc_pkg::div_acc_t          acc  [N+1];
  dctl_t                      ctl  [N+1];
  logic                       done_q;
  logic signed [15:0]         cos_q, cos_d;
  logic                       zero_q;

  assign num = {side_i.mag, 6'd0};

  // First stage: a quotient of 2^16 or more saturates whatever its sign.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    acc[0].rem <= num[pgc_pkg::NUM_W-1:LO];
    acc[0].quo <= '0;
    ctl[0].zero <= side_i.zero;
    ctl[0].neg  <= side_i.neg;
    ctl[0].ovf  <= num[pgc_pkg::NUM_W-1:LO] >= {1'b0, root_i};
    ctl[0].root <= root_i;
    ctl[0].low  <= num[LO-1:0];
  end

  for (genvar g = 0; g < N; g++) begin : g_stage
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[g+1] <= 1'b0;
      end else begin
        vld[g+1] <= vld[g];
      end
    end

    always_ff @(posedge clk_i) begin
      acc[g+1] <= pgc_pkg::div_step(pgc_pkg::div_step(acc[g], ctl[g].low[LO-1], ctl[g].root),
                                    ctl[g].low[LO-2], ctl[g].root);
      ctl[g+1] <= {ctl[g].zero, ctl[g].neg, ctl[g].ovf, ctl[g].root, ctl[g].low << 2};
    end
  end

  always_comb begin
    priority if (ctl[N].zero) begin
      cos_d = 16'sd0;
    end else if (ctl[N].neg) begin
      if (ctl[N].ovf || (acc[N].quo > 16'd32768)) begin
        cos_d = -16'sd32768;
      end else begin
        cos_d = 16'(-acc[N].quo);
      end
    end else begin
      if (ctl[N].ovf || acc[N].quo[15]) begin
        cos_d = 16'sd32767;
      end else begin
        cos_d = acc[N].quo;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld[N];
    end
  end

  always_ff @(posedge clk_i) begin
    cos_q  <= cos_d;
    zero_q <= ctl[N].zero;
  end

  assign done_o = done_q;
  assign cos_o  = cos_q;
  assign zero_o = zero_q;

endmodule

>>> rtl/core/pgc_back.sv
// Back end: geometry stores, particle position, squares and dot product, then root and divide.
// Depends on pgc_pkg, pgc_sqrt and pgc_div.
module pgc_back #(
  parameter int RINGS       = 32,
  parameter int SECTORS     = 32,
  parameter int GE_MODULES  = 8,
  parameter int GE_CHANNELS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                item_vld_i,
  input  pgc_pkg::item_t      item_i,
  input  pgc_pkg::cfg_t       cfg_i,
  output logic                done_o,
  output logic signed [15:0]  cos_o,
  output logic                zero_o
);

  localparam int GDEPTH = GE_MODULES * GE_CHANNELS;
  localparam int RAW    = (RINGS > 1) ? $clog2(RINGS) : 1;
  localparam int SAW    = (SECTORS > 1) ? $clog2(SECTORS) : 1;
  localparam int GAW    = (GDEPTH > 1) ? $clog2(GDEPTH) : 1;
  localparam int DW     = pgc_pkg::DELTA_W;

  logic signed [23:0] ring_mem [RINGS];
  logic [31:0]        sec_mem  [SECTORS];
  logic [47:0]        gam_mem  [GDEPTH];

  logic [RAW-1:0] ring_addr;
  logic [SAW-1:0] sec_addr;
  logic [GAW-1:0] gam_addr;

  assign ring_addr = RAW'(item_i.ring);
  assign sec_addr  = SAW'(item_i.sector);
  assign gam_addr  = GAW'(item_i.gidx);

  // Loads and compute reads leave the queue in order, so a read sees every earlier load.
  always_ff @(posedge clk_i) begin
    if (item_vld_i && (item_i.mode == pgc_pkg::MODE_LOAD_RING) && item_i.ring_ok) begin
      ring_mem[ring_addr] <= item_i.tx;
    end
    if (item_vld_i && (item_i.mode == pgc_pkg::MODE_LOAD_SECTOR) && item_i.sec_ok) begin
      sec_mem[sec_addr] <= {item_i.tx[15:0], item_i.ty};
    end
    if (item_vld_i && (item_i.mode == pgc_pkg::MODE_LOAD_GAMMA) && item_i.gam_ok) begin
      gam_mem[gam_addr] <= {item_i.tx[15:0], item_i.ty, item_i.tz};
    end
  end

  logic signed [23:0] ring_rd_q;
  logic [31:0]        sec_rd_q;
  logic [47:0]        gam_rd_q;
  logic               s1_vld_q, s1_rok_q, s1_sok_q, s1_gok_q;

  always_ff @(posedge clk_i) begin
    ring_rd_q <= ring_mem[ring_addr];
    sec_rd_q  <= sec_mem[sec_addr];
    gam_rd_q  <= gam_mem[gam_addr];
    s1_rok_q  <= item_i.ring_ok;
    s1_sok_q  <= item_i.sec_ok;
    s1_gok_q  <= item_i.gam_ok;
  end

  // Stage 1: out-of-range indices read as zero; rotate the radius onto the sector direction.
  logic signed [23:0] r1;
  logic signed [15:0] c1, sn1;
  logic [47:0]        g1;
  logic               s2_vld_q;
  logic signed [39:0] pc_q, ps_q;
  logic signed [15:0] gx2_q, gy2_q, gz2_q;

  assign r1  = s1_rok_q ? ring_rd_q : 24'sd0;
  assign c1  = s1_sok_q ? sec_rd_q[31:16] : 16'sd0;
  assign sn1 = s1_sok_q ? sec_rd_q[15:0] : 16'sd0;
  assign g1  = s1_gok_q ? gam_rd_q : 48'd0;

  always_ff @(posedge clk_i) begin
    pc_q  <= r1 * c1;
    ps_q  <= r1 * sn1;
    gx2_q <= g1[47:32];
    gy2_q <= g1[31:16];
    gz2_q <= g1[15:0];
  end

  // Stage 2: round to length units and subtract the beam spot.
  logic signed [40:0]   pcr, psr;
  logic signed [DW-1:0] dx_d, dy_d, dz_d;
  logic signed [DW-1:0] dx_q, dy_q, dz_q;
  logic signed [15:0]   gx3_q, gy3_q, gz3_q;
  logic                 s3_vld_q;

  always_comb begin
    pcr  = 41'(pc_q) + 41'sd16384;
    psr  = 41'(ps_q) + 41'sd16384;
    dx_d = DW'(pcr[40:15]) - DW'(cfg_i.beam_x);
    dy_d = DW'(psr[40:15]) - DW'(cfg_i.beam_y);
    dz_d = DW'($signed({1'b0, cfg_i.target_dist})) - DW'(cfg_i.beam_z);
  end

  always_ff @(posedge clk_i) begin
    dx_q  <= dx_d;
    dy_q  <= dy_d;
    dz_q  <= dz_d;
    gx3_q <= gx2_q;
    gy3_q <= gy2_q;
    gz3_q <= gz2_q;
  end

  // Stage 3: squares and products.
  logic signed [2*DW-1:0]            sqx, sqy, sqz;
  logic [pgc_pkg::SQ_W-1:0]          sqx_q, sqy_q, sqz_q;
  logic signed [pgc_pkg::PROD_W-1:0] prx_q, pry_q, prz_q;
  logic                              s4_vld_q;

  assign sqx = dx_q * dx_q;
  assign sqy = dy_q * dy_q;
  assign sqz = dz_q * dz_q;

  always_ff @(posedge clk_i) begin
    sqx_q <= sqx[pgc_pkg::SQ_W-1:0];
    sqy_q <= sqy[pgc_pkg::SQ_W-1:0];
    sqz_q <= sqz[pgc_pkg::SQ_W-1:0];
    prx_q <= dx_q * gx3_q;
    pry_q <= dy_q * gy3_q;
    prz_q <= dz_q * gz3_q;
  end

  // Stage 4: sums.
  logic [pgc_pkg::SUM_W-1:0]        sum_q;
  logic signed [pgc_pkg::DOT_W-1:0] dot_q;
  logic                             s5_vld_q;
  logic signed [pgc_pkg::DOT_W-1:0] dot_abs;
  pgc_pkg::side_t                   side;
  logic [pgc_pkg::RAD_W-1:0]        rad;

  always_ff @(posedge clk_i) begin
    sum_q <= pgc_pkg::SUM_W'(sqx_q) + pgc_pkg::SUM_W'(sqy_q) + pgc_pkg::SUM_W'(sqz_q);
    dot_q <= pgc_pkg::DOT_W'(prx_q) + pgc_pkg::DOT_W'(pry_q) + pgc_pkg::DOT_W'(prz_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= item_vld_i && (item_i.mode == pgc_pkg::MODE_COMPUTE);
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
      s5_vld_q <= s4_vld_q;
    end
  end

  assign dot_abs   = dot_q[pgc_pkg::DOT_W-1] ? -dot_q : dot_q;
  assign side.zero = (sum_q == '0);
  assign side.neg  = dot_q[pgc_pkg::DOT_W-1];
  assign side.mag  = pgc_pkg::MAG_W'(dot_abs);
  assign rad       = pgc_pkg::RAD_W'({sum_q, 12'd0});

  logic                        sq_vld;
  logic [pgc_pkg::ROOT_W-1:0]  sq_root;
  pgc_pkg::side_t              sq_side;

  pgc_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (s5_vld_q),
    .rad_i  (rad),
    .side_i (side),
    .vld_o  (sq_vld),
    .root_o (sq_root),
    .side_o (sq_side)
  );

  pgc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (sq_vld),
    .root_i (sq_root),
    .side_i (sq_side),
    .done_o (done_o),
    .cos_o  (cos_o),
    .zero_o (zero_o)
  );

endmodule

>>> rtl/core/particle_gamma_cosine.sv
// Cosine of the particle-gamma angle for Doppler correction: top level of the block.
// A new command transaction is taken every clock cycle while busy is low; a compute command's
// result passes through the command queue, the store read, four arithmetic stages, the 16-stage
// square root, the 9-stage divider and the output register, and a load command gives none.
// The receiver cannot stall: each result appears for one cycle with done_o high, in command
// order. busy rises only when the four-entry command queue is full. Configuration is to be
// written by the user only while no command is in flight; the block does not enforce this.
// Depends on pgc_pkg, pgc_cfg, pgc_front and pgc_back.
module particle_gamma_cosine #(
  parameter int RINGS       = 32,
  parameter int SECTORS     = 32,
  parameter int GE_MODULES  = 8,
  parameter int GE_CHANNELS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         mode_i,
  input  logic [2:0]         ge_module_i,
  input  logic [3:0]         ge_channel_i,
  input  logic [4:0]         si_ring_i,
  input  logic [4:0]         si_sector_i,
  input  logic signed [23:0] table_x_i,
  input  logic signed [15:0] table_y_i,
  input  logic signed [15:0] table_z_i,
  output logic               done_o,
  output logic signed [15:0] cos_angle_o,
  output logic               zero_distance_o
);

  pgc_pkg::cfg_t  cfg;
  pgc_pkg::item_t item;
  logic           item_vld;

  pgc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pgc_front #(
    .RINGS       (RINGS),
    .SECTORS     (SECTORS),
    .GE_MODULES  (GE_MODULES),
    .GE_CHANNELS (GE_CHANNELS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .mode_i       (mode_i),
    .ge_module_i  (ge_module_i),
    .ge_channel_i (ge_channel_i),
    .si_ring_i    (si_ring_i),
    .si_sector_i  (si_sector_i),
    .table_x_i    (table_x_i),
    .table_y_i    (table_y_i),
    .table_z_i    (table_z_i),
    .item_vld_o   (item_vld),
    .item_o       (item)
  );

  pgc_back #(
    .RINGS       (RINGS),
    .SECTORS     (SECTORS),
    .GE_MODULES  (GE_MODULES),
    .GE_CHANNELS (GE_CHANNELS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_vld_i (item_vld),
    .item_i     (item),
    .cfg_i      (cfg),
    .done_o     (done_o),
    .cos_o      (cos_angle_o),
    .zero_o     (zero_distance_o)
  );

endmodule

>>> dv/particle_gamma_cosine_tb.sv
// Self-checking testbench for particle_gamma_cosine: commands are driven through the
// start/busy handshake and results are compared with a behavioural predictor of the block.
// Depends on pgc_pkg and the particle_gamma_cosine RTL.
module particle_gamma_cosine_tb;

  typedef struct {
    pgc_pkg::mode_e mode;
    logic [2:0]  gmod;
    logic [3:0]  gch;
    logic [4:0]  ring;
    logic [4:0]  sec;
    logic [23:0] tx;
    logic [15:0] ty;
    logic [15:0] tz;
  } cmd_t;

  typedef struct {
    logic [15:0] cosv;
    logic        zero;
  } cosine_t;

  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 60;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic busy;
  logic [1:0] mode_i = '0;
  logic [2:0] ge_module_i = '0;
  logic [3:0] ge_channel_i = '0;
  logic [4:0] si_ring_i = '0;
  logic [4:0] si_sector_i = '0;
  logic signed [23:0] table_x_i = '0;
  logic signed [15:0] table_y_i = '0;
  logic signed [15:0] table_z_i = '0;
  logic done_o;
  logic signed [15:0] cos_angle_o;
  logic zero_distance_o;

  particle_gamma_cosine DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state.
  logic signed [23:0] beam_x_m, beam_y_m, beam_z_m;
  logic [22:0] target_dist_m;
  logic signed [23:0] radius_m [32];
  logic signed [15:0] sec_cos_m [32], sec_sin_m [32];
  logic signed [15:0] gam_m [128][3];
  bit ring_set [32], sec_set [32], gam_set [128];

  cmd_t pending_cmds[$];
  cosine_t expected_cosines[$];
  int failures = 0;
  int idle_cycles = 0;
  bit stim_done = 1'b0;
  bit hold_off = 1'b0;

  function automatic longint unsigned isqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else res >>= 1;
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint rnd15(longint v);
    v += 16384;
    return v >>> 15;
  endfunction

  // Updates the stores or predicts the cosine of one command.
  function automatic void predict_cosine(cmd_t c);
    longint r, cs, sn, gx, gy, gz, dx, dy, dz, dot, q;
    longint unsigned sum, root, mag;
    int gi;
    cosine_t e;
    gi = int'({c.gmod, c.gch});
    case (c.mode)
      pgc_pkg::MODE_LOAD_RING: begin
        radius_m[c.ring] = c.tx;
        ring_set[c.ring] = 1;
      end
      pgc_pkg::MODE_LOAD_SECTOR: begin
        sec_cos_m[c.sec] = c.tx[15:0];
        sec_sin_m[c.sec] = c.ty;
        sec_set[c.sec] = 1;
      end
      pgc_pkg::MODE_LOAD_GAMMA: begin
        gam_m[gi][0] = c.tx[15:0];
        gam_m[gi][1] = c.ty;
        gam_m[gi][2] = c.tz;
        gam_set[gi] = 1;
      end
      default: begin
        r = radius_m[c.ring];
        cs = sec_cos_m[c.sec];
        sn = sec_sin_m[c.sec];
        gx = gam_m[gi][0];
        gy = gam_m[gi][1];
        gz = gam_m[gi][2];
        dx = rnd15(r * cs) - longint'(beam_x_m);
        dy = rnd15(r * sn) - longint'(beam_y_m);
        dz = longint'({1'b0, target_dist_m}) - longint'(beam_z_m);
        sum = dx * dx + dy * dy + dz * dz;
        if (sum == 0) begin
          e.cosv = 0;
          e.zero = 1;
        end else begin
          root = isqrt(sum << 12);
          dot = dx * gx + dy * gy + dz * gz;
          mag = dot < 0 ? -dot : dot;
          q = (mag << 6) / root;
          if (dot < 0) q = -q;
          if (q > 32767) q = 32767;
          if (q < -32768) q = -32768;
          e.cosv = q[15:0];
          e.zero = 0;
        end
        expected_cosines.push_back(e);
      end
    endcase
  endfunction

  function automatic logic [15:0] rand_q15();
    case ($urandom_range(0, 5))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic cmd_t mk(pgc_pkg::mode_e m, int gm, int gc, int rg, int sc,
                              logic [23:0] x, logic [15:0] y, logic [15:0] z);
    cmd_t c;
    c.mode = m; c.gmod = 3'(gm); c.gch = 4'(gc); c.ring = 5'(rg); c.sec = 5'(sc);
    c.tx = x; c.ty = y; c.tz = z;
    return c;
  endfunction

  // Random command; computes only touch entries already loaded.
  function automatic cmd_t rand_cmd();
    cmd_t c;
    int k;
    c = mk(pgc_pkg::mode_e'($urandom_range(0, 3)), $urandom_range(0, 7),
           $urandom_range(0, 15), $urandom_range(0, 31), $urandom_range(0, 31),
           24'($urandom), rand_q15(), rand_q15());
    if ($urandom_range(0, 1)) c.mode = pgc_pkg::MODE_COMPUTE;
    if (c.mode == pgc_pkg::MODE_LOAD_RING) begin
      k = $urandom_range(0, 3);
      if (k == 0) c.tx = 24'h7fffff;
      else if (k == 1) c.tx = 24'h800000;
      else if (k == 2) c.tx = 24'($urandom_range(0, 40000));
    end else if (c.mode == pgc_pkg::MODE_LOAD_SECTOR) begin
      if ($urandom_range(0, 1)) c.tx[15:0] = rand_q15();
    end
    if (c.mode == pgc_pkg::MODE_COMPUTE && !(ring_set[c.ring] && sec_set[c.sec] &&
        gam_set[{c.gmod, c.gch}]))
      c.mode = pgc_pkg::MODE_LOAD_GAMMA;
    return c;
  endfunction

  // Driver.
  int gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        void'(pending_cmds.pop_front());
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0) gap = 0;
      end
      if (!(start && busy)) begin
        if (pending_cmds.size() > 0 && gap == 0 && !hold_off) begin
          start <= 1'b1;
          mode_i <= pending_cmds[0].mode;
          ge_module_i <= pending_cmds[0].gmod;
          ge_channel_i <= pending_cmds[0].gch;
          si_ring_i <= pending_cmds[0].ring;
          si_sector_i <= pending_cmds[0].sec;
          table_x_i <= pending_cmds[0].tx;
          table_y_i <= pending_cmds[0].ty;
          table_z_i <= pending_cmds[0].tz;
        end else begin
          start <= 1'b0;
          if (gap > 0) gap--;
        end
      end
    end
  end

  // Monitor: predicts at acceptance, checks each result against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        predict_cosine(mk(pgc_pkg::mode_e'(mode_i), ge_module_i, ge_channel_i, si_ring_i,
                          si_sector_i, table_x_i, table_y_i, table_z_i));
        idle_cycles = 0;
      end else if (done_o) idle_cycles = 0;
      else idle_cycles++;
      if (done_o) begin
        if (expected_cosines.size() == 0) begin
          $display("%0t: unexpected result cos_angle %h", $time, cos_angle_o);
          failures++;
        end else begin
          if (cos_angle_o !== expected_cosines[0].cosv) begin
            $display("%0t: cos_angle expected %h actual %h", $time,
                     expected_cosines[0].cosv, cos_angle_o);
            failures++;
          end
          if (zero_distance_o !== expected_cosines[0].zero) begin
            $display("%0t: zero_distance expected %b actual %b", $time,
                     expected_cosines[0].zero, zero_distance_o);
            failures++;
          end
          void'(expected_cosines.pop_front());
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic wait_quiet();
    while (pending_cmds.size() > 0 || expected_cosines.size() > 0 || start)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(pgc_pkg::reg_e idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 4'(idx) << 2; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    case (idx)
      pgc_pkg::REG_BEAM_X: beam_x_m = val[23:0];
      pgc_pkg::REG_BEAM_Y: beam_y_m = val[23:0];
      pgc_pkg::REG_BEAM_Z: beam_z_m = val[23:0];
      default: target_dist_m = val[22:0];
    endcase
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic run_random(int n);
    repeat (n) pending_cmds.push_back(rand_cmd());
  endtask

  initial begin
    int p;
    beam_x_m = 0; beam_y_m = 0; beam_z_m = 0; target_dist_m = pgc_pkg::TD_RESET;
    foreach (radius_m[i]) begin
      radius_m[i] = 0; sec_cos_m[i] = 0; sec_sin_m[i] = 0;
    end
    foreach (gam_m[i]) begin
      gam_m[i][0] = 0; gam_m[i][1] = 0; gam_m[i][2] = 0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extreme loads, a zero length and saturating unit vectors.
    pending_cmds.push_back(mk(pgc_pkg::MODE_LOAD_RING, 0, 0, 0, 0, 24'h7fffff, 0, 0));
    pending_cmds.push_back(mk(pgc_pkg::MODE_LOAD_RING, 0, 0, 31, 0, 24'h800000, 0, 0));
    pending_cmds.push_back(mk(pgc_pkg::MODE_LOAD_RING, 0, 0, 5, 0, 24'd0, 0, 0));
    pending_cmds.push_back(mk(pgc_pkg::MODE_LOAD_SECTOR, 0, 0, 0, 0, 24'hff7fff, 16'h8000, 0));
    pending_cmds.push_back(mk(pgc_pkg::MODE_LOAD_SECTOR, 0, 0, 0, 31, 24'h008000, 16'h7fff, 0));
    pending_cmds.push_back(mk(pgc_pkg::MODE_LOAD_GAMMA, 0, 0, 0, 0, 24'h7fff, 16'h7fff,
                              16'h7fff));
    pending_cmds.push_back(mk(pgc_pkg::MODE_LOAD_GAMMA, 7, 15, 0, 0, 24'hff8000, 16'h8000,
                              16'h8000));
    pending_cmds.push_back(mk(pgc_pkg::MODE_COMPUTE, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk(pgc_pkg::MODE_COMPUTE, 7, 15, 31, 31, 24'hffffff, 16'hffff,
                              16'hffff));
    pending_cmds.push_back(mk(pgc_pkg::MODE_COMPUTE, 0, 0, 5, 0, 0, 0, 0));
    pending_cmds.push_back(mk(pgc_pkg::MODE_COMPUTE, 7, 15, 5, 31, 0, 0, 0));
    foreach (pending_cmds[i]) begin
      if (pending_cmds[i].mode == pgc_pkg::MODE_LOAD_RING) ring_set[pending_cmds[i].ring] = 1;
    end
    wait_quiet();
    // Zero length: ring 5 has radius 0, so a beam spot at the target gives S = 0.
    write_reg(pgc_pkg::REG_BEAM_Z, 32'd2202);
    pending_cmds.push_back(mk(pgc_pkg::MODE_COMPUTE, 0, 0, 5, 0, 0, 0, 0));
    wait_quiet();
    write_reg(pgc_pkg::REG_TARGET_DIST, 32'h7fffff);
    write_reg(pgc_pkg::REG_BEAM_X, 32'h800000);
    write_reg(pgc_pkg::REG_BEAM_Y, 32'h7fffff);
    write_reg(pgc_pkg::REG_BEAM_Z, 32'h800000);
    pending_cmds.push_back(mk(pgc_pkg::MODE_COMPUTE, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk(pgc_pkg::MODE_COMPUTE, 7, 15, 31, 31, 0, 0, 0));
    wait_quiet();

    // Random phases under several register settings.
    for (p = 0; p < 6; p++) begin
      case (p)
        0: begin
          write_reg(pgc_pkg::REG_BEAM_X, 0); write_reg(pgc_pkg::REG_BEAM_Y, 0);
          write_reg(pgc_pkg::REG_BEAM_Z, 0); write_reg(pgc_pkg::REG_TARGET_DIST, 0);
        end
        1: write_reg(pgc_pkg::REG_TARGET_DIST, 32'(pgc_pkg::TD_RESET));
        2: begin
          write_reg(pgc_pkg::REG_BEAM_X, $urandom_range(0, 511) - 256);
          write_reg(pgc_pkg::REG_BEAM_Y, $urandom_range(0, 511) - 256);
          write_reg(pgc_pkg::REG_BEAM_Z, $urandom_range(0, 511) - 256);
        end
        3: begin
          write_reg(pgc_pkg::REG_BEAM_X, $urandom); write_reg(pgc_pkg::REG_BEAM_Y, $urandom);
          write_reg(pgc_pkg::REG_BEAM_Z, $urandom);
          write_reg(pgc_pkg::REG_TARGET_DIST, $urandom);
        end
        4: write_reg(pgc_pkg::REG_TARGET_DIST, 32'h7fffff);
        default: begin
          write_reg(pgc_pkg::REG_BEAM_X, 0); write_reg(pgc_pkg::REG_BEAM_Y, 0);
          write_reg(pgc_pkg::REG_BEAM_Z, 0);
          write_reg(pgc_pkg::REG_TARGET_DIST, 32'(pgc_pkg::TD_RESET));
        end
      endcase
      run_random(130);
      // The sender holds off until the block has emptied, then continues.
      while (pending_cmds.size() > 65) @(posedge clk_i);
      hold_off = 1'b1;
      while (start || expected_cosines.size() > 0) @(posedge clk_i);
      hold_off = 1'b0;
      run_random(125);
      wait_quiet();
    end

    if (failures == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule

>>> filelist.f
rtl/core/pgc_pkg.sv
rtl/core/pgc_cfg.sv
rtl/core/pgc_front.sv
rtl/core/pgc_sqrt.sv
rtl/core/pgc_div.sv
rtl/core/pgc_back.sv
rtl/core/particle_gamma_cosine.sv
dv/particle_gamma_cosine_tb.sv
